FILE: design/blpv_pkg.sv
// blpv_pkg: shared constants, register codes, item structs and table builders
// for the blinn-phong vertex lighting unit; no dependencies
`timescale 1ns / 1ps

package blpv_pkg;

  localparam int POW_TABLE_ADDR_BITS = 8;
  localparam int UNIT_FRAC = 14;
  localparam int QUOT_BITS = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_AMBIENT   = 3'd1,
    CFG_DIFFUSE   = 3'd2,
    CFG_SPECULAR  = 3'd3,
    CFG_SHININESS = 3'd4,
    CFG_LIGHT_X   = 3'd5,
    CFG_LIGHT_Y   = 3'd6,
    CFG_LIGHT_Z   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } vtx_attr_t;

  typedef struct packed {
    vtx_attr_t attr;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;
  } half_tag_t;

  typedef struct packed {
    logic [15:0] ndl;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } pow_tag_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // log2 of (1 + j/2^b), q.16
  function automatic logic [16:0] log_entry(input int j, input int b);
    logic [63:0] y;
    logic [31:0] bits;
    if (j >= (1 << b)) return 17'h10000;
    y = 64'((1 << b) + j) << (30 - b);
    bits = '0;
    for (int k = 0; k < 17; k++) begin
      y = (y * y) >> 30;
      bits = bits << 1;
      if (y >= 64'h8000_0000) begin
        bits = bits | 32'd1;
        y = y >> 1;
      end
    end
    return 17'((bits + 32'd1) >> 1);
  endfunction

  // 2^(-j/2^b), q.16
  function automatic logic [16:0] exp_entry(input int j, input int b);
    logic [63:0] fac [13];
    logic [63:0] r;
    logic [63:0] p;
    if (j >= (1 << b)) return 17'h08000;
    fac[0] = 64'd1 << 30;
    r = 64'd1 << 29;
    for (int i = 1; i <= 12; i++) begin
      r = isqrt64(r << 30);
      fac[i] = r;
    end
    p = 64'd1 << 30;
    for (int i = 1; i <= b; i++) begin
      if (((j >> (b - i)) & 1) != 0) p = (p * fac[i]) >> 30;
    end
    return 17'((p + (64'd1 << 13)) >> 14);
  endfunction

endpackage

FILE: design/blinn_phong_vertex_lighting_unit.sv
// blinn_phong_vertex_lighting_unit: top level, config registers, direction and
// dot stages, color mix; uses blpv_pkg, blpv_norm and blpv_pow
// accepts one item per cycle, busy stays low
// throughput is set by the fully pipelined square root and divide stages
// rst_n clears the config registers and the valid chain; results cannot be stalled
`timescale 1ns / 1ps

module blinn_phong_vertex_lighting_unit #(
  parameter int POW_TABLE_ADDR_BITS = blpv_pkg::POW_TABLE_ADDR_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [23:0] in_vertex_x,
  input  logic signed [23:0] in_vertex_y,
  input  logic signed [23:0] in_vertex_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [15:0] in_base_red,
  input  logic [15:0] in_base_green,
  input  logic [15:0] in_base_blue,
  input  logic [15:0] in_base_alpha,
  output logic out_valid,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  input  logic cfg_wr_en,
  input  logic [blpv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blpv_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic enable_r;
  logic [47:0] amb_r;
  logic [47:0] dif_r;
  logic [47:0] spc_r;
  logic [15:0] shin_r;
  logic signed [23:0] light_x_r;
  logic signed [23:0] light_y_r;
  logic signed [23:0] light_z_r;

  logic vld0_r;
  logic signed [24:0] dir_r [2][3];
  blpv_pkg::vtx_attr_t attr0_r;

  logic n1_vld;
  logic signed [15:0] n1_u [2][3];
  logic [$bits(blpv_pkg::vtx_attr_t)-1:0] n1_tag;
  blpv_pkg::vtx_attr_t attr1;

  logic vld1_r;
  logic signed [16:0] half_r [1][3];
  blpv_pkg::half_tag_t htag1_r;

  logic n2_vld;
  logic signed [15:0] n2_u [1][3];
  logic [$bits(blpv_pkg::half_tag_t)-1:0] n2_tag;
  blpv_pkg::half_tag_t htag2;

  logic vld2_r;
  logic signed [31:0] pl_r [3];
  logic signed [31:0] ph_r [3];
  blpv_pkg::vtx_attr_t attr2_r;

  logic vld3_r;
  logic [15:0] ndh_r;
  blpv_pkg::pow_tag_t ptag3_r;

  logic p_vld;
  logic [15:0] pw;
  logic [$bits(blpv_pkg::pow_tag_t)-1:0] p_tag;
  blpv_pkg::pow_tag_t ptag4;

  logic vld4_r;
  logic [15:0] amb4_r [3];
  logic [16:0] td4_r [3];
  logic [16:0] ts4_r [3];
  logic [15:0] base4_r [4];

  logic [17:0] sum5 [3];
  logic vld5_r;
  logic [15:0] col5_r [4];

  function automatic logic [15:0] dot_clamp(input logic signed [33:0] d);
    logic [33:0] q;
    q = (34'(d) + 34'd4096) >> 13;
    if (d <= 0) return '0;
    if (q > 34'd32768) return blpv_pkg::ONE_Q15;
    return q[15:0];
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      amb_r <= '0;
      dif_r <= '0;
      spc_r <= '0;
      shin_r <= '0;
      light_x_r <= '0;
      light_y_r <= '0;
      light_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (blpv_pkg::cfg_reg_t'(cfg_index))
        blpv_pkg::CFG_ENABLE:    enable_r <= cfg_data[0];
        blpv_pkg::CFG_AMBIENT:   amb_r <= cfg_data[47:0];
        blpv_pkg::CFG_DIFFUSE:   dif_r <= cfg_data[47:0];
        blpv_pkg::CFG_SPECULAR:  spc_r <= cfg_data[47:0];
        blpv_pkg::CFG_SHININESS: shin_r <= cfg_data[15:0];
        blpv_pkg::CFG_LIGHT_X:   light_x_r <= cfg_data[23:0];
        blpv_pkg::CFG_LIGHT_Y:   light_y_r <= cfg_data[23:0];
        blpv_pkg::CFG_LIGHT_Z:   light_z_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // light and eye directions
  always_ff @(posedge clk) begin
    dir_r[0][0] <= 25'(light_x_r) - 25'(in_vertex_x);
    dir_r[0][1] <= 25'(light_y_r) - 25'(in_vertex_y);
    dir_r[0][2] <= 25'(light_z_r) - 25'(in_vertex_z);
    dir_r[1][0] <= 25'sd0 - 25'(in_vertex_x);
    dir_r[1][1] <= 25'sd0 - 25'(in_vertex_y);
    dir_r[1][2] <= 25'sd0 - 25'(in_vertex_z);
    attr0_r.nx <= in_normal_x;
    attr0_r.ny <= in_normal_y;
    attr0_r.nz <= in_normal_z;
    attr0_r.red <= in_base_red;
    attr0_r.green <= in_base_green;
    attr0_r.blue <= in_base_blue;
    attr0_r.alpha <= in_base_alpha;
  end

  blpv_norm #(
    .DW(25),
    .NVEC(2),
    .TW($bits(blpv_pkg::vtx_attr_t))
  ) u_norm_dir (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(vld0_r),
    .in_d(dir_r),
    .in_tag(attr0_r),
    .out_valid(n1_vld),
    .out_u(n1_u),
    .out_tag(n1_tag)
  );

  assign attr1 = n1_tag;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      half_r[0][c] <= 17'(n1_u[0][c]) + 17'(n1_u[1][c]);
    end
    htag1_r.attr <= attr1;
    htag1_r.lx <= n1_u[0][0];
    htag1_r.ly <= n1_u[0][1];
    htag1_r.lz <= n1_u[0][2];
  end

  blpv_norm #(
    .DW(17),
    .NVEC(1),
    .TW($bits(blpv_pkg::half_tag_t))
  ) u_norm_half (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(vld1_r),
    .in_d(half_r),
    .in_tag(htag1_r),
    .out_valid(n2_vld),
    .out_u(n2_u),
    .out_tag(n2_tag)
  );

  assign htag2 = n2_tag;

  always_ff @(posedge clk) begin
    pl_r[0] <= 32'(htag2.attr.nx) * 32'(htag2.lx);
    pl_r[1] <= 32'(htag2.attr.ny) * 32'(htag2.ly);
    pl_r[2] <= 32'(htag2.attr.nz) * 32'(htag2.lz);
    ph_r[0] <= 32'(htag2.attr.nx) * 32'(n2_u[0][0]);
    ph_r[1] <= 32'(htag2.attr.ny) * 32'(n2_u[0][1]);
    ph_r[2] <= 32'(htag2.attr.nz) * 32'(n2_u[0][2]);
    attr2_r <= htag2.attr;

    ptag3_r.ndl <= dot_clamp(34'(pl_r[0]) + 34'(pl_r[1]) + 34'(pl_r[2]));
    ndh_r <= dot_clamp(34'(ph_r[0]) + 34'(ph_r[1]) + 34'(ph_r[2]));
    ptag3_r.red <= attr2_r.red;
    ptag3_r.green <= attr2_r.green;
    ptag3_r.blue <= attr2_r.blue;
    ptag3_r.alpha <= attr2_r.alpha;
  end

  blpv_pow #(
    .PB(POW_TABLE_ADDR_BITS),
    .TW($bits(blpv_pkg::pow_tag_t))
  ) u_pow (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(vld3_r),
    .in_x(ndh_r),
    .in_shin(shin_r),
    .in_tag(ptag3_r),
    .out_valid(p_vld),
    .out_pw(pw),
    .out_tag(p_tag)
  );

  assign ptag4 = p_tag;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum5[c] = 18'(amb4_r[c]) + 18'(td4_r[c]) + 18'(ts4_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      amb4_r[c] <= amb_r[16*c +: 16];
      td4_r[c] <= 17'((32'(dif_r[16*c +: 16]) * 32'(ptag4.ndl) + 32'd16384) >> 15);
      ts4_r[c] <= 17'((32'(spc_r[16*c +: 16]) * 32'(pw) + 32'd16384) >> 15);
    end
    base4_r[0] <= ptag4.red;
    base4_r[1] <= ptag4.green;
    base4_r[2] <= ptag4.blue;
    base4_r[3] <= ptag4.alpha;

    for (int c = 0; c < 3; c++) begin
      if (!enable_r) begin
        col5_r[c] <= base4_r[c];
      end else if (sum5[c] > 18'h0FFFF) begin
        col5_r[c] <= 16'hFFFF;
      end else begin
        col5_r[c] <= sum5[c][15:0];
      end
    end
    col5_r[3] <= enable_r ? blpv_pkg::ONE_Q15 : base4_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld0_r <= start && !busy;
      vld1_r <= n1_vld;
      vld2_r <= n2_vld;
      vld3_r <= vld2_r;
      vld4_r <= p_vld;
      vld5_r <= vld4_r;
    end
  end

  assign out_valid = vld5_r;
  assign out_red = col5_r[0];
  assign out_green = col5_r[1];
  assign out_blue = col5_r[2];
  assign out_alpha = col5_r[3];

endmodule

FILE: design/blpv_norm.sv
// blpv_norm: pipelined vector normalizer, squares, bit-serial square root
// stages and restoring divide stages; uses blpv_pkg
`timescale 1ns / 1ps

module blpv_norm #(
  parameter int DW = 25,
  parameter int NVEC = 1,
  parameter int TW = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic signed [DW-1:0] in_d [NVEC][3],
  input  logic [TW-1:0] in_tag,
  output logic out_valid,
  output logic signed [15:0] out_u [NVEC][3],
  output logic [TW-1:0] out_tag
);

  localparam int QB = blpv_pkg::QUOT_BITS;
  localparam int SW = 2 * DW + 2;
  localparam int NS = SW / 2;
  localparam int RW = DW + QB + 1;
  localparam int LAT = NS + QB + 5;

  logic [DW-1:0] mag_a_r [NVEC][3];
  logic sgn_a_r [NVEC][3];
  logic [2*DW-1:0] sq_b_r [NVEC][3];
  logic [DW-1:0] mag_b_r [NVEC][3];
  logic sgn_b_r [NVEC][3];
  logic [SW-1:0] sv_r [NS+1][NVEC];
  logic [SW-1:0] sr_r [NS+1][NVEC];
  logic [DW-1:0] mag_s_r [NS+1][NVEC][3];
  logic sgn_s_r [NS+1][NVEC][3];
  logic [RW-1:0] rem_r [QB+1][NVEC][3];
  logic [QB-1:0] q_r [QB+1][NVEC][3];
  logic [NS-1:0] len_r [QB+1][NVEC];
  logic sgn_d_r [QB+1][NVEC][3];
  logic signed [15:0] u_r [NVEC][3];
  logic [LAT-1:0] vld_r;
  logic [TW-1:0] tag_r [LAT];

  always_ff @(posedge clk) begin
    for (int n = 0; n < NVEC; n++) begin
      for (int c = 0; c < 3; c++) begin
        mag_a_r[n][c] <= in_d[n][c][DW-1] ? DW'(-in_d[n][c]) : DW'(in_d[n][c]);
        sgn_a_r[n][c] <= in_d[n][c][DW-1];
        sq_b_r[n][c] <= (2*DW)'(mag_a_r[n][c]) * (2*DW)'(mag_a_r[n][c]);
        mag_b_r[n][c] <= mag_a_r[n][c];
        sgn_b_r[n][c] <= sgn_a_r[n][c];
        mag_s_r[0][n][c] <= mag_b_r[n][c];
        sgn_s_r[0][n][c] <= sgn_b_r[n][c];
      end
      sv_r[0][n] <= SW'(sq_b_r[n][0]) + SW'(sq_b_r[n][1]) + SW'(sq_b_r[n][2]);
      sr_r[0][n] <= '0;

      // square root, one result bit per stage
      for (int k = 0; k < NS; k++) begin
        if (sv_r[k][n] >= sr_r[k][n] + (SW'(1) << (2 * (NS - 1 - k)))) begin
          sv_r[k+1][n] <= sv_r[k][n] - (sr_r[k][n] + (SW'(1) << (2 * (NS - 1 - k))));
          sr_r[k+1][n] <= (sr_r[k][n] >> 1) + (SW'(1) << (2 * (NS - 1 - k)));
        end else begin
          sv_r[k+1][n] <= sv_r[k][n];
          sr_r[k+1][n] <= sr_r[k][n] >> 1;
        end
        for (int c = 0; c < 3; c++) begin
          mag_s_r[k+1][n][c] <= mag_s_r[k][n][c];
          sgn_s_r[k+1][n][c] <= sgn_s_r[k][n][c];
        end
      end

      len_r[0][n] <= sr_r[NS][n][NS-1:0];
      for (int c = 0; c < 3; c++) begin
        rem_r[0][n][c] <= (RW'(mag_s_r[NS][n][c]) << blpv_pkg::UNIT_FRAC)
                          + RW'(sr_r[NS][n][NS-1:1]);
        q_r[0][n][c] <= '0;
        sgn_d_r[0][n][c] <= sgn_s_r[NS][n][c];
      end

      // rounded quotient, one bit per stage
      for (int k = 0; k < QB; k++) begin
        len_r[k+1][n] <= len_r[k][n];
        for (int c = 0; c < 3; c++) begin
          if (rem_r[k][n][c] >= (RW'(len_r[k][n]) << (QB - 1 - k))) begin
            rem_r[k+1][n][c] <= rem_r[k][n][c] - (RW'(len_r[k][n]) << (QB - 1 - k));
            q_r[k+1][n][c] <= {q_r[k][n][c][QB-2:0], 1'b1};
          end else begin
            rem_r[k+1][n][c] <= rem_r[k][n][c];
            q_r[k+1][n][c] <= {q_r[k][n][c][QB-2:0], 1'b0};
          end
          sgn_d_r[k+1][n][c] <= sgn_d_r[k][n][c];
        end
      end

      for (int c = 0; c < 3; c++) begin
        if (len_r[QB][n] == '0) begin
          u_r[n][c] <= '0;
        end else if (sgn_d_r[QB][n][c]) begin
          u_r[n][c] <= -$signed({1'b0, q_r[QB][n][c]});
        end else begin
          u_r[n][c] <= $signed({1'b0, q_r[QB][n][c]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int k = 1; k < LAT; k++) tag_r[k] <= tag_r[k-1];
  end

  assign out_valid = vld_r[LAT-1];
  assign out_tag = tag_r[LAT-1];
  assign out_u = u_r;

endmodule

FILE: design/blpv_pow.sv
// blpv_pow: pipelined power x^s as exp2(s*log2(x)) with interpolated tables
// uses blpv_pkg for the table builders
`timescale 1ns / 1ps

module blpv_pow #(
  parameter int PB = blpv_pkg::POW_TABLE_ADDR_BITS,
  parameter int TW = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [15:0] in_x,
  input  logic [15:0] in_shin,
  input  logic [TW-1:0] in_tag,
  output logic out_valid,
  output logic [15:0] out_pw,
  output logic [TW-1:0] out_tag
);

  localparam int TabLen = (1 << PB) + 1;
  localparam int LSH = 15 - PB;
  localparam int ESH = 16 - PB;
  localparam int LAT = 9;

  logic [16:0] log_tab [TabLen];
  logic [16:0] exp_tab [TabLen];

  for (genvar j = 0; j < TabLen; j++) begin : g_tab
    assign log_tab[j] = blpv_pkg::log_entry(j, PB);
    assign exp_tab[j] = blpv_pkg::exp_entry(j, PB);
  end

  logic [3:0] lead;
  logic [15:0] mant;
  logic [16+LSH:0] lprod;
  logic [16+ESH:0] eprod;
  logic [17:0] rnd;

  logic one_r [LAT-1];
  logic zero_r [LAT-1];
  logic [3:0] lead_r [3];
  logic [PB-1:0] lidx_r;
  logic [LSH-1:0] lrem_r [2];
  logic [16:0] llo_r;
  logic [16:0] ldif_r;
  logic [16:0] lf_r;
  logic [19:0] neg_r;
  logic [27:0] e_r;
  logic [3:0] ip_r [3];
  logic [PB-1:0] eidx_r;
  logic [ESH-1:0] erem_r [2];
  logic [16:0] elo_r;
  logic [16:0] edif_r;
  logic [16:0] v_r;
  logic [15:0] pw_r;
  logic [LAT-1:0] vld_r;
  logic [TW-1:0] tag_r [LAT];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 15; i++) begin
      if (in_x[i]) lead = 4'(i);
    end
    mant = {1'b0, in_x[14:0]} << (4'd15 - lead);
    lprod = (17+LSH)'(ldif_r) * (17+LSH)'(lrem_r[1]);
    eprod = (17+ESH)'(edif_r) * (17+ESH)'(erem_r[1]);
    rnd = (18'(v_r) + (18'd1 << ip_r[2])) >> (ip_r[2] + 5'd1);
  end

  always_ff @(posedge clk) begin
    one_r[0] <= (in_shin == '0) || (in_x >= blpv_pkg::ONE_Q15);
    zero_r[0] <= (in_shin != '0) && (in_x == '0);
    for (int k = 1; k < LAT - 1; k++) begin
      one_r[k] <= one_r[k-1];
      if (k == 5) begin
        // exponent out of range flushes to zero
        zero_r[k] <= zero_r[k-1] || (e_r[27:20] != '0);
      end else begin
        zero_r[k] <= zero_r[k-1];
      end
    end

    lead_r[0] <= lead;
    lidx_r <= mant[14:LSH];
    lrem_r[0] <= mant[LSH-1:0];

    llo_r <= log_tab[(PB+1)'(lidx_r)];
    ldif_r <= log_tab[(PB+1)'(lidx_r) + (PB+1)'(1)] - log_tab[(PB+1)'(lidx_r)];
    lrem_r[1] <= lrem_r[0];
    lead_r[1] <= lead_r[0];

    lf_r <= llo_r + 17'(lprod >> LSH);
    lead_r[2] <= lead_r[1];

    neg_r <= (20'(4'd15 - lead_r[2]) << 16) - 20'(lf_r);

    e_r <= 28'((36'(neg_r) * 36'(in_shin)) >> 8);

    ip_r[0] <= e_r[19:16];
    eidx_r <= e_r[15:ESH];
    erem_r[0] <= e_r[ESH-1:0];

    elo_r <= exp_tab[(PB+1)'(eidx_r)];
    edif_r <= exp_tab[(PB+1)'(eidx_r)] - exp_tab[(PB+1)'(eidx_r) + (PB+1)'(1)];
    erem_r[1] <= erem_r[0];
    ip_r[1] <= ip_r[0];

    v_r <= elo_r - 17'(eprod >> ESH);
    ip_r[2] <= ip_r[1];

    if (one_r[LAT-2]) begin
      pw_r <= blpv_pkg::ONE_Q15;
    end else if (zero_r[LAT-2]) begin
      pw_r <= '0;
    end else begin
      pw_r <= rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int k = 1; k < LAT; k++) tag_r[k] <= tag_r[k-1];
  end

  assign out_valid = vld_r[LAT-1];
  assign out_pw = pw_r;
  assign out_tag = tag_r[LAT-1];

endmodule
